### hw/rtl/sefs_pkg.sv
// Shared constants for the spring edge force and stiffness block.
`default_nettype none
package sefs_pkg;
    localparam int COORD_W = 32;
    localparam int REST_W  = 31;
    localparam int FORCE_W = 32;
    localparam int STIFF_W = 32;
    localparam int S_TDATA_W = 224;
    localparam int M_TDATA_W = 224;
    localparam logic [FORCE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [FORCE_W-1:0] SAT_NEG = 32'h8000_0000;
endpackage
`default_nettype wire

### hw/rtl/spring_edge_force_stiffness_top.sv
// Top level of the spring edge force and stiffness pipeline.
`default_nettype none
// One spring edge enters per item: the two end positions and the rest length, all
// fixed point with FRAC_BITS fraction bits. The block returns the restoring force on
// each end (equal and opposite, saturated to 32 bits), the stiffness modulus divided
// by the rest length, and a flag for a zero-length edge, whose forces are zero. It is
// a single pipeline of 42 + FRAC_BITS register stages (58 at the default), and a new
// item is taken every cycle while the result side keeps up. The depth is set by the
// square root, which settles one bit of the edge length per stage over 33 stages,
// followed by the direction divide, one quotient bit per stage. The stiffness divide
// runs beside the root. The whole pipeline moves together: when the result is held,
// every stage holds and s_tready is low. The modulus register may be written only
// while no item is in flight.
module spring_edge_force_stiffness_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [31:0]                     cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // node_a_x, node_a_y, node_a_z, node_b_x, node_b_y, node_b_z, rest_length, pad
    input  wire logic [sefs_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // force_a_x, force_a_y, force_a_z, force_b_x, force_b_y, force_b_z,
    // block_stiffness
    output logic [sefs_pkg::M_TDATA_W-1:0]       m_tdata,
    // degenerate
    output logic                                 m_tuser
);
    import sefs_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int RW   = 33;           // root bits
    localparam int KPW  = 33 + F;       // stiffness times direction
    localparam int MW   = 66 - F;       // force magnitude after the shift
    localparam int SQ0  = 3;            // first root stage
    localparam int ST_E = SQ0 + RW;     // edge error and divider setup
    localparam int DV0  = ST_E + 1;     // first direction divide stage
    localparam int ST_P = DV0 + F + 1;
    localparam int ST_PP = ST_P + 1;
    localparam int ST_SM = ST_PP + 1;
    localparam int ST_O  = ST_SM + 1;
    localparam int NST   = ST_O + 1;

    typedef struct packed {
        logic [2:0][32:0]     dm;
        logic [2:0]           dneg;
        logic [REST_W-1:0]    rest;
        logic                 degen;
        logic [2:0][65:0]     sq;
        logic [66:0]          srem;
        logic [RW-1:0]        root;
        logic [30:0]          krem;
        logic [31:0]          kq;
        logic                 kovf;
        logic [STIFF_W-1:0]   k;
        logic                 eneg;
        logic [32:0]          emag;
        logic [2:0][32:0]     drem;
        logic [2:0][F:0]      nm;
        logic [2:0][KPW-1:0]  p;
        logic [2:0][KPW+16:0] pplo;
        logic [2:0][KPW+15:0] pphi;
        logic [2:0][MW-1:0]   mag;
        logic [2:0]           fneg;
        logic [2:0][31:0]     fa;
        logic [2:0][31:0]     fb;
    } pipe_t;

    logic [31:0] modulus_reg;
    pipe_t       pipe_reg  [NST];
    pipe_t       pipe_next [NST];
    logic [NST-1:0] valid_reg;
    logic        adv;

    assign adv      = !valid_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[NST-1];
    assign m_tuser  = pipe_reg[NST-1].degen;
    assign m_tdata  = {pipe_reg[NST-1].k,
                       pipe_reg[NST-1].fb[2], pipe_reg[NST-1].fb[1], pipe_reg[NST-1].fb[0],
                       pipe_reg[NST-1].fa[2], pipe_reg[NST-1].fa[1], pipe_reg[NST-1].fa[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= 32'(1) << F;
        end else if (cfg_we) begin
            modulus_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NST-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < NST; s++) begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

    for (genvar s = 0; s < NST; s++) begin : g_st
        if (s == 0) begin : g_diff
            always_comb begin
                logic [32:0] df;
                pipe_next[s] = '0;
                for (int i = 0; i < 3; i++) begin
                    df = {s_tdata[32*i+31], s_tdata[32*i +: 32]}
                       - {s_tdata[96+32*i+31], s_tdata[96+32*i +: 32]};
                    pipe_next[s].dneg[i] = df[32];
                    pipe_next[s].dm[i]   = df[32] ? 33'(-df) : df;
                end
                pipe_next[s].rest  = s_tdata[192 +: REST_W];
                pipe_next[s].degen = (pipe_next[s].dm == '0);
            end
        end else if (s == 1) begin : g_sq
            always_comb begin
                pipe_next[s] = pipe_reg[s-1];
                for (int i = 0; i < 3; i++) begin
                    pipe_next[s].sq[i] = 66'(pipe_reg[s-1].dm[i]) * 66'(pipe_reg[s-1].dm[i]);
                end
            end
        end else if (s == 2) begin : g_sum
            always_comb begin
                logic [31:0] mhi;
                pipe_next[s] = pipe_reg[s-1];
                pipe_next[s].srem = 67'(pipe_reg[s-1].sq[0]) + 67'(pipe_reg[s-1].sq[1])
                                  + 67'(pipe_reg[s-1].sq[2]);
                pipe_next[s].root = '0;
                // Quotient overflows 32 bits exactly when the upper part of the
                // dividend already reaches the divisor.
                mhi = modulus_reg >> (32 - F);
                pipe_next[s].kovf = (mhi >= {1'b0, pipe_reg[s-1].rest});
                pipe_next[s].krem = mhi[30:0];
                pipe_next[s].kq   = '0;
            end
        end else if (s < ST_E) begin : g_root
            localparam int B  = RW - 1 - (s - SQ0);
            localparam int J  = s - SQ0;
            localparam bit KSTEP = (J < 32);
            localparam int JI = KSTEP ? (31 - J) : 0;
            always_comb begin
                logic [66:0]   strial;
                logic [31:0]   ktrial;
                logic [31+F:0] dvd;
                pipe_next[s] = pipe_reg[s-1];
                strial = (67'(pipe_reg[s-1].root) << (B + 1)) + (67'(1) << (2 * B));
                if (pipe_reg[s-1].srem >= strial) begin
                    pipe_next[s].srem    = pipe_reg[s-1].srem - strial;
                    pipe_next[s].root[B] = 1'b1;
                end
                dvd    = {modulus_reg, {F{1'b0}}};
                ktrial = {pipe_reg[s-1].krem, dvd[JI]};
                if (KSTEP) begin
                    if (ktrial >= {1'b0, pipe_reg[s-1].rest}) begin
                        pipe_next[s].krem   = 31'(ktrial - {1'b0, pipe_reg[s-1].rest});
                        pipe_next[s].kq[JI] = 1'b1;
                    end else begin
                        pipe_next[s].krem = ktrial[30:0];
                    end
                end
            end
        end else if (s == ST_E) begin : g_err
            always_comb begin
                logic [33:0] e;
                pipe_next[s] = pipe_reg[s-1];
                pipe_next[s].k = pipe_reg[s-1].kovf ? '1 : pipe_reg[s-1].kq;
                e = {1'b0, pipe_reg[s-1].root} - {3'b000, pipe_reg[s-1].rest};
                pipe_next[s].eneg = e[33];
                pipe_next[s].emag = e[33] ? 33'(-e) : e[32:0];
                for (int i = 0; i < 3; i++) begin
                    pipe_next[s].drem[i] = pipe_reg[s-1].dm[i] >> 1;
                    pipe_next[s].nm[i]   = '0;
                end
            end
        end else if (s < ST_P) begin : g_dir
            localparam int T = F - (s - DV0);
            always_comb begin
                logic [33:0] dtrial;
                pipe_next[s] = pipe_reg[s-1];
                for (int i = 0; i < 3; i++) begin
                    dtrial = {pipe_reg[s-1].drem[i],
                              (T == F) ? pipe_reg[s-1].dm[i][0] : 1'b0};
                    if (dtrial >= {1'b0, pipe_reg[s-1].root}) begin
                        pipe_next[s].drem[i]  = 33'(dtrial - {1'b0, pipe_reg[s-1].root});
                        pipe_next[s].nm[i][T] = 1'b1;
                    end else begin
                        pipe_next[s].drem[i] = dtrial[32:0];
                    end
                end
            end
        end else if (s == ST_P) begin : g_kn
            always_comb begin
                pipe_next[s] = pipe_reg[s-1];
                for (int i = 0; i < 3; i++) begin
                    pipe_next[s].p[i] = KPW'(pipe_reg[s-1].k) * KPW'(pipe_reg[s-1].nm[i]);
                    pipe_next[s].fneg[i] = !(pipe_reg[s-1].eneg ^ pipe_reg[s-1].dneg[i]);
                end
            end
        end else if (s == ST_PP) begin : g_pp
            always_comb begin
                pipe_next[s] = pipe_reg[s-1];
                for (int i = 0; i < 3; i++) begin
                    pipe_next[s].pplo[i] = (KPW+17)'(pipe_reg[s-1].p[i])
                                         * (KPW+17)'(pipe_reg[s-1].emag[16:0]);
                    pipe_next[s].pphi[i] = (KPW+16)'(pipe_reg[s-1].p[i])
                                         * (KPW+16)'(pipe_reg[s-1].emag[32:17]);
                end
            end
        end else if (s == ST_SM) begin : g_sum_pp
            always_comb begin
                logic [KPW+32:0] full;
                pipe_next[s] = pipe_reg[s-1];
                for (int i = 0; i < 3; i++) begin
                    full = (KPW+33)'(pipe_reg[s-1].pplo[i])
                         + ((KPW+33)'(pipe_reg[s-1].pphi[i]) << 17);
                    pipe_next[s].mag[i] = full[KPW+32:2*F];
                end
            end
        end else begin : g_out
            always_comb begin
                logic        big;
                logic [31:0] m32;
                logic [31:0] vpos;
                logic [31:0] vneg;
                pipe_next[s] = pipe_reg[s-1];
                for (int i = 0; i < 3; i++) begin
                    big  = |pipe_reg[s-1].mag[i][MW-1:32];
                    m32  = pipe_reg[s-1].mag[i][31:0];
                    vpos = (big || m32 > SAT_POS) ? SAT_POS : m32;
                    vneg = (big || m32 > SAT_NEG) ? SAT_NEG : m32;
                    vneg = 32'(-vneg);
                    if (pipe_reg[s-1].degen) begin
                        pipe_next[s].fa[i] = '0;
                        pipe_next[s].fb[i] = '0;
                    end else if (pipe_reg[s-1].fneg[i]) begin
                        pipe_next[s].fa[i] = vneg;
                        pipe_next[s].fb[i] = vpos;
                    end else begin
                        pipe_next[s].fa[i] = vpos;
                        pipe_next[s].fb[i] = vneg;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire
